[hw/rtl/tcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tcm_pkg;

    localparam logic [1:0] FUNC_FEED    = 2'd0;
    localparam logic [1:0] FUNC_RAPID   = 2'd1;
    localparam logic [1:0] FUNC_RETRACT = 2'd2;

    localparam logic [1:0] KIND_FEED    = 2'd0;
    localparam logic [1:0] KIND_RAPID   = 2'd1;
    localparam logic [1:0] KIND_RETRACT = 2'd2;

    localparam logic [1:0] REG_MAX_ERROR      = 2'd0;
    localparam logic [1:0] REG_X_OFFSET       = 2'd1;
    localparam logic [1:0] REG_Y_OFFSET       = 2'd2;
    localparam logic [1:0] REG_RETRACT_HEIGHT = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [15:0]        MAX_RUN           = 16'hFFFF;
    localparam logic signed [23:0] FIVE_MM           = 24'sd1280;
    localparam logic [15:0]        MAX_ERROR_RESET   = 16'd3;
    localparam logic signed [23:0] RETRACT_RESET     = 24'sd922;
    localparam logic signed [34:0] NEAR_LIMIT        = 35'sd65535;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        move_kind;
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic signed [23:0] out_z;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       diff;
        logic       sq_en;
        logic [1:0] sq_axis;
        logic       extend;
        logic       emit_pend;
        logic       pend_last;
        logic       emit_point;
        logic       start_run;
        logic       emit_rapid;
        logic       emit_retract;
    } tcm_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       run_nz;
        logic       run_max;
        logic       after_flush;
        logic       div_done;
        logic       fit;
        logic       out_free;
    } tcm_status_t;

    function automatic logic signed [23:0] sat24(input logic signed [34:0] v);
        if (v > 35'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -35'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/tcm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcm_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] dividend,
    input  wire logic [15:0]        divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic        neg_reg;
    logic [16:0] trial;
    logic [31:0] mag;

    assign mag   = dividend[31] ? 32'(-dividend) : 32'(dividend);
    assign trial = {rem_reg, quo_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            neg_reg <= dividend[31];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= 16'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule
`default_nettype wire

[hw/rtl/tcm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tcm_pkg::tcm_status_t status,
    output tcm_pkg::tcm_cmd_t        cmd
);
    import tcm_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_DISPATCH = 12'b000000000010,
        S_DIV      = 12'b000000000100,
        S_DIFF     = 12'b000000001000,
        S_SQ_X     = 12'b000000010000,
        S_SQ_Y     = 12'b000000100000,
        S_SQ_Z     = 12'b000001000000,
        S_DECIDE   = 12'b000010000000,
        S_PEND     = 12'b000100000000,
        S_START    = 12'b001000000000,
        S_POINT    = 12'b010000000000,
        S_EMIT     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.func == FUNC_FEED)
                begin
                    if (status.run_nz && !status.run_max)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else if (status.run_nz)
                        state_next = S_PEND;
                    else if (status.after_flush)
                        state_next = S_POINT;
                    else
                        state_next = S_START;
                end
                else if (status.func == FUNC_RAPID || status.func == FUNC_RETRACT)
                    state_next = status.run_nz ? S_PEND : S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
                if (status.div_done)
                    state_next = S_DIFF;
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SQ_X;
            end
            S_SQ_X:
            begin
                cmd.sq_en   = 1'b1;
                cmd.sq_axis = AXIS_X;
                state_next  = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                cmd.sq_en   = 1'b1;
                cmd.sq_axis = AXIS_Y;
                state_next  = S_SQ_Z;
            end
            S_SQ_Z:
            begin
                cmd.sq_en   = 1'b1;
                cmd.sq_axis = AXIS_Z;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.fit)
                begin
                    cmd.extend = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_PEND;
            end
            S_PEND:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pend = 1'b1;
                    cmd.pend_last = (status.func == FUNC_FEED) && !status.after_flush;
                    if (status.func != FUNC_FEED)
                        state_next = S_EMIT;
                    else if (status.after_flush)
                        state_next = S_POINT;
                    else
                        state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start_run = 1'b1;
                state_next    = S_IDLE;
            end
            S_POINT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_point = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_rapid   = (status.func == FUNC_RAPID);
                    cmd.emit_retract = (status.func == FUNC_RETRACT);
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/tcm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcm_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcm_pkg::in_item_t   in_item,
    input  wire logic                cfg_valid,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output tcm_pkg::out_item_t       out_item,
    input  wire tcm_pkg::tcm_cmd_t   cmd,
    output tcm_pkg::tcm_status_t     status
);
    import tcm_pkg::*;

    logic [15:0]        max_error_reg;
    logic signed [23:0] x_offset_reg, y_offset_reg, retract_height_reg;

    logic signed [23:0] base_x_reg, base_y_reg, base_z_reg;
    logic signed [31:0] delta_x_reg, delta_y_reg, delta_z_reg;
    logic [15:0]        run_count_reg;
    logic               after_flush_reg;

    in_item_t           item_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic [15:0]        mag_x_reg, mag_y_reg, mag_z_reg;
    logic               ok_reg;
    logic [33:0]        acc_reg;

    logic               done_x, done_y, done_z;
    logic signed [31:0] q_x, q_y, q_z;
    logic signed [34:0] ext_x, ext_y, ext_z;
    logic signed [34:0] dif_x, dif_y, dif_z;
    logic signed [23:0] pend_x, pend_y, pend_z;
    logic [15:0]        sq_mag;
    logic [31:0]        sq;
    logic [31:0]        lim;
    logic               emit_any;

    tcm_div u_div_x (.clk, .rst_n, .start(cmd.div_start), .dividend(delta_x_reg),
                     .divisor(run_count_reg), .done(done_x), .quotient(q_x));
    tcm_div u_div_y (.clk, .rst_n, .start(cmd.div_start), .dividend(delta_y_reg),
                     .divisor(run_count_reg), .done(done_y), .quotient(q_y));
    tcm_div u_div_z (.clk, .rst_n, .start(cmd.div_start), .dividend(delta_z_reg),
                     .divisor(run_count_reg), .done(done_z), .quotient(q_z));

    assign ext_x = 35'(delta_x_reg) + 35'(q_x);
    assign ext_y = 35'(delta_y_reg) + 35'(q_y);
    assign ext_z = 35'(delta_z_reg) + 35'(q_z);

    assign dif_x = 35'(base_x_reg) + ext_x - 35'(item_reg.pos_x);
    assign dif_y = 35'(base_y_reg) + ext_y - 35'(item_reg.pos_y);
    assign dif_z = 35'(base_z_reg) + ext_z - 35'(item_reg.pos_z);

    assign pend_x = sat24(35'(base_x_reg) + 35'(delta_x_reg));
    assign pend_y = sat24(35'(base_y_reg) + 35'(delta_y_reg));
    assign pend_z = sat24(35'(base_z_reg) + 35'(delta_z_reg));

    always_comb
    begin
        case (cmd.sq_axis)
            AXIS_X:  sq_mag = mag_x_reg;
            AXIS_Y:  sq_mag = mag_y_reg;
            AXIS_Z:  sq_mag = mag_z_reg;
            default: sq_mag = '0;
        endcase
    end

    assign sq  = sq_mag * sq_mag;
    assign lim = max_error_reg * max_error_reg;

    assign emit_any = cmd.emit_pend | cmd.emit_point | cmd.emit_rapid | cmd.emit_retract;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_error_reg      <= MAX_ERROR_RESET;
            x_offset_reg       <= '0;
            y_offset_reg       <= '0;
            retract_height_reg <= RETRACT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_ERROR:      max_error_reg      <= cfg_data[15:0];
                REG_X_OFFSET:       x_offset_reg       <= cfg_data;
                REG_Y_OFFSET:       y_offset_reg       <= cfg_data;
                REG_RETRACT_HEIGHT: retract_height_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg      <= '0;
            base_y_reg      <= '0;
            base_z_reg      <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            delta_z_reg     <= '0;
            run_count_reg   <= '0;
            after_flush_reg <= 1'b0;
        end
        else
        begin
            if (cmd.extend)
            begin
                delta_x_reg   <= sat32(ext_x);
                delta_y_reg   <= sat32(ext_y);
                delta_z_reg   <= sat32(ext_z);
                run_count_reg <= run_count_reg + 16'd1;
            end
            if (cmd.emit_pend)
            begin
                base_x_reg    <= pend_x;
                base_y_reg    <= pend_y;
                base_z_reg    <= pend_z;
                delta_x_reg   <= '0;
                delta_y_reg   <= '0;
                delta_z_reg   <= '0;
                run_count_reg <= '0;
            end
            if (cmd.emit_point)
            begin
                base_x_reg      <= item_reg.pos_x;
                base_y_reg      <= item_reg.pos_y;
                base_z_reg      <= item_reg.pos_z;
                delta_x_reg     <= '0;
                delta_y_reg     <= '0;
                delta_z_reg     <= '0;
                after_flush_reg <= 1'b0;
            end
            if (cmd.start_run)
            begin
                delta_x_reg   <= 32'(35'(item_reg.pos_x) - 35'(base_x_reg));
                delta_y_reg   <= 32'(35'(item_reg.pos_y) - 35'(base_y_reg));
                delta_z_reg   <= 32'(35'(item_reg.pos_z) - 35'(base_z_reg));
                run_count_reg <= 16'd1;
            end
            if (cmd.emit_rapid || cmd.emit_retract)
            begin
                delta_x_reg     <= '0;
                delta_y_reg     <= '0;
                delta_z_reg     <= '0;
                run_count_reg   <= '0;
                after_flush_reg <= 1'b1;
            end
            if (cmd.emit_rapid)
            begin
                base_x_reg <= item_reg.pos_x;
                base_y_reg <= item_reg.pos_y;
                base_z_reg <= item_reg.pos_z;
            end
            if (cmd.emit_retract)
                base_z_reg <= FIVE_MM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
        if (cmd.diff)
        begin
            mag_x_reg <= dif_x[34] ? 16'(-dif_x) : dif_x[15:0];
            mag_y_reg <= dif_y[34] ? 16'(-dif_y) : dif_y[15:0];
            mag_z_reg <= dif_z[34] ? 16'(-dif_z) : dif_z[15:0];
            ok_reg    <= (dif_x <= NEAR_LIMIT) && (dif_x >= -NEAR_LIMIT) &&
                         (dif_y <= NEAR_LIMIT) && (dif_y >= -NEAR_LIMIT) &&
                         (dif_z <= NEAR_LIMIT) && (dif_z >= -NEAR_LIMIT);
        end
        if (cmd.sq_en)
            acc_reg <= ((cmd.sq_axis == AXIS_X) ? 34'd0 : acc_reg) + 34'(sq);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_any)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pend)
        begin
            out_item_reg.move_kind <= KIND_FEED;
            out_item_reg.out_x     <= sat24(35'(pend_x) + 35'(x_offset_reg));
            out_item_reg.out_y     <= sat24(35'(pend_y) + 35'(y_offset_reg));
            out_item_reg.out_z     <= pend_z;
            out_item_reg.last      <= cmd.pend_last;
        end
        else if (cmd.emit_point || cmd.emit_rapid)
        begin
            out_item_reg.move_kind <= cmd.emit_rapid ? KIND_RAPID : KIND_FEED;
            out_item_reg.out_x     <= sat24(35'(item_reg.pos_x) + 35'(x_offset_reg));
            out_item_reg.out_y     <= sat24(35'(item_reg.pos_y) + 35'(y_offset_reg));
            out_item_reg.out_z     <= item_reg.pos_z;
            out_item_reg.last      <= 1'b1;
        end
        else if (cmd.emit_retract)
        begin
            out_item_reg.move_kind <= KIND_RETRACT;
            out_item_reg.out_x     <= '0;
            out_item_reg.out_y     <= '0;
            out_item_reg.out_z     <= retract_height_reg;
            out_item_reg.last      <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign status.func        = item_reg.func;
    assign status.run_nz      = (run_count_reg != 16'd0);
    assign status.run_max     = (run_count_reg == MAX_RUN);
    assign status.after_flush = after_flush_reg;
    assign status.div_done    = done_x & done_y & done_z;
    assign status.fit         = ok_reg && (acc_reg < 34'(lim));
    assign status.out_free    = !out_valid_reg || out_ready;
endmodule
`default_nettype wire

[hw/rtl/toolpath_collinear_merger_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Collinear toolpath point merger.
// in_*  : one point per transaction (func, pos_x/y/z). in_ready is high only
//         while the controller is idle, so one point is worked on at a time.
// out_* : zero, one or two moves per point; last marks the final one.
// cfg_* : register writes (index 0..3), always ready; write only when idle.
// Steps per point:
//   feed point extending a run: capture, dispatch, serial divide of the
//   three deltas by the run count, diff, three squaring steps, decide
//   feed point ending a run after the compare: the same steps, then the
//   pending move and a new run start or point, plus output stalls
//   first feed point of a run, rapid, retract, feed at the run length limit:
//   capture, dispatch, then the pending, start or emit states plus output stalls
// The serial divider takes most of the time for a merged point.
// A result sits in a single output register; the next point is accepted
// while the final result of the previous one is still waiting. When out_ready
// is low and a second result is due, the controller holds until the register
// frees.
// Reset clears the run state and loads register defaults (tolerance 3,
// offsets 0, retract height 922); the output register comes up empty.
module toolpath_collinear_merger_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tcm_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tcm_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);
    import tcm_pkg::*;

    tcm_cmd_t    cmd;
    tcm_status_t status;

    assign cfg_ready = 1'b1;

    tcm_ctrl u_ctrl (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .status,
        .cmd
    );

    tcm_dp u_dp (
        .clk,
        .rst_n,
        .in_item,
        .cfg_valid,
        .cfg_index,
        .cfg_data,
        .out_ready,
        .out_valid,
        .out_item,
        .cmd,
        .status
    );
endmodule
`default_nettype wire

[tb/toolpath_collinear_merger_core_tb.sv]
`timescale 1ns / 1ps

module toolpath_collinear_merger_core_tb;
    import tcm_pkg::*;

    class path_merge_scoreboard;
        out_item_t expected_moves[$];
        int        errors;
        longint    tol;
        longint    x_off;
        longint    y_off;
        longint    lift_z;
        longint    bx;
        longint    by;
        longint    bz;
        longint    dx;
        longint    dy;
        longint    dz;
        longint    run_len;
        bit        flushed;

        function new();
            errors  = 0;
            tol     = 3;
            x_off   = 0;
            y_off   = 0;
            lift_z  = 922;
            bx      = 0;
            by      = 0;
            bz      = 0;
            dx      = 0;
            dy      = 0;
            dz      = 0;
            run_len = 0;
            flushed = 0;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            hi = (longint'(1) <<< (w - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                REG_MAX_ERROR:      tol = data[15:0];
                REG_X_OFFSET:       x_off = longint'($signed(data));
                REG_Y_OFFSET:       y_off = longint'($signed(data));
                REG_RETRACT_HEIGHT: lift_z = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function void push_move(logic [1:0] kind, longint x, longint y, longint z);
            out_item_t m;
            m.move_kind = kind;
            m.out_x     = x[23:0];
            m.out_y     = y[23:0];
            m.out_z     = z[23:0];
            m.last      = 1'b0;
            expected_moves.push_back(m);
        endfunction

        function void feed_move(longint x, longint y, longint z);
            push_move(KIND_FEED, clamp(x + x_off, 24), clamp(y + y_off, 24), z);
            bx = x;
            by = y;
            bz = z;
            dx = 0;
            dy = 0;
            dz = 0;
        endfunction

        function void emit_run_end();
            feed_move(clamp(bx + dx, 24), clamp(by + dy, 24), clamp(bz + dz, 24));
        endfunction

        function bit axis_fits(longint d, longint b, longint p, inout longint acc);
            longint diff;
            diff = b + (d * (run_len + 1)) / run_len - p;
            if (diff > 65535 || diff < -65535)
                return 0;
            acc += diff * diff;
            return 1;
        endfunction

        function void note_input(in_item_t it);
            longint px;
            longint py;
            longint pz;
            longint acc;
            bit     ok;
            int     prev_count;
            px = longint'(it.pos_x);
            py = longint'(it.pos_y);
            pz = longint'(it.pos_z);
            prev_count = expected_moves.size();
            case (it.func)
                FUNC_FEED:
                begin
                    if (run_len > 0)
                    begin
                        if (run_len < longint'(MAX_RUN))
                        begin
                            acc = 0;
                            ok = axis_fits(dx, bx, px, acc) && axis_fits(dy, by, py, acc)
                                 && axis_fits(dz, bz, pz, acc);
                            if (ok && acc < tol * tol)
                            begin
                                dx = clamp((dx * (run_len + 1)) / run_len, 32);
                                dy = clamp((dy * (run_len + 1)) / run_len, 32);
                                dz = clamp((dz * (run_len + 1)) / run_len, 32);
                                run_len++;
                                return;
                            end
                        end
                        emit_run_end();
                        run_len = 0;
                    end
                    if (flushed)
                    begin
                        feed_move(px, py, pz);
                        flushed = 0;
                    end
                    else
                    begin
                        dx = px - bx;
                        dy = py - by;
                        dz = pz - bz;
                        run_len = 1;
                    end
                end
                FUNC_RAPID, FUNC_RETRACT:
                begin
                    if (run_len > 0)
                        emit_run_end();
                    run_len = 0;
                    dx = 0;
                    dy = 0;
                    dz = 0;
                    flushed = 1;
                    if (it.func == FUNC_RAPID)
                    begin
                        push_move(KIND_RAPID, clamp(px + x_off, 24), clamp(py + y_off, 24), pz);
                        bx = px;
                        by = py;
                        bz = pz;
                    end
                    else
                    begin
                        push_move(KIND_RETRACT, 0, 0, lift_z);
                        bz = longint'(FIVE_MM);
                    end
                end
                default: ;
            endcase
            if (expected_moves.size() > prev_count)
                expected_moves[expected_moves.size() - 1].last = 1'b1;
        endfunction

        function void check(out_item_t got);
            out_item_t want;
            if (expected_moves.size() == 0)
            begin
                $display("%0t: unexpected move %p", $time, got);
                errors++;
                return;
            end
            want = expected_moves.pop_front();
            if (got.move_kind !== want.move_kind)
                $display("%0t: move_kind expected %0d actual %0d", $time, want.move_kind,
                         got.move_kind);
            if (got.out_x !== want.out_x)
                $display("%0t: out_x expected %0d actual %0d", $time, want.out_x, got.out_x);
            if (got.out_y !== want.out_y)
                $display("%0t: out_y expected %0d actual %0d", $time, want.out_y, got.out_y);
            if (got.out_z !== want.out_z)
                $display("%0t: out_z expected %0d actual %0d", $time, want.out_z, got.out_z);
            if (got.last !== want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    path_merge_scoreboard sb;
    bit          hold_request;
    int          burst_left;
    longint      cycles;

    toolpath_collinear_merger_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // transactions are sampled at the edge, before nonblocking updates land
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check(out_item);
    end

    // receiver: random stall pattern, plus one long hold-off on request
    initial
    begin
        int hold;
        out_ready = 1'b0;
        hold_request = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                hold = 600;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if ((cycles / 2000) % 3 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_point(in_item_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic send(logic [1:0] f, longint x, longint y, longint z);
        in_item_t it;
        it.func  = f;
        it.pos_x = x[23:0];
        it.pos_y = y[23:0];
        it.pos_z = z[23:0];
        send_point(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_moves.size() != 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int count);
        int     n;
        int     len;
        int     sel;
        longint sx;
        longint sy;
        longint sz;
        longint stx;
        longint sty;
        longint stz;
        int     jit;
        n = 0;
        while (n < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                len = $urandom_range(2, 14);
                sx = $signed($urandom_range(0, 8000000)) - 4000000;
                sy = $signed($urandom_range(0, 8000000)) - 4000000;
                sz = $signed($urandom_range(0, 8000000)) - 4000000;
                stx = $signed($urandom_range(0, 4000)) - 2000;
                sty = $signed($urandom_range(0, 4000)) - 2000;
                stz = $signed($urandom_range(0, 400)) - 200;
                jit = $urandom_range(0, 2) == 0 ? $urandom_range(0, 4) : 0;
                for (int k = 0; k < len; k++)
                    send(FUNC_FEED, sx + k * stx + $signed($urandom_range(0, 2 * jit)) - jit,
                         sy + k * sty, sz + k * stz);
                n += len;
            end
            else
            begin
                if (sel < 75)
                    send(FUNC_RAPID, $urandom, $urandom, $urandom);
                else if (sel < 85)
                    send(FUNC_RETRACT, $urandom, $urandom, $urandom);
                else if (sel < 95)
                    send(FUNC_FEED, $urandom, $urandom, $urandom);
                else
                    send(2'd3, $urandom, $urandom, $urandom);
                if (sel < 95)
                    n++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_ERROR;
        cfg_data  = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: runs, flushes, far points, extremes, unused func
        send(FUNC_FEED, 10, 20, 30);
        send(FUNC_FEED, 20, 40, 60);
        send(FUNC_FEED, 30, 60, 90);
        send(FUNC_FEED, 41, 60, 90);
        send(FUNC_RAPID, 100, 100, 100);
        send(FUNC_FEED, 200, 100, 100);
        send(FUNC_FEED, 300, 100, 100);
        send(FUNC_FEED, 400, 100, 100);
        send(FUNC_FEED, -400, -100, 100);
        send(FUNC_RETRACT, 5, 5, 5);
        send(FUNC_FEED, 8388607, 8388607, 8388607);
        send(FUNC_FEED, -8388608, -8388608, -8388608);
        send(FUNC_FEED, 8388607, -8388608, 0);
        send(FUNC_FEED, 8388607, -8388608, 0);
        send(FUNC_RAPID, -8388608, 8388607, -8388608);
        send(2'd3, -1, -1, -1);
        send(FUNC_FEED, 0, 0, 0);
        send(FUNC_FEED, 70000, 0, 0);
        send(FUNC_RETRACT, 0, 0, 0);
        send(FUNC_RETRACT, 0, 0, 0);
        random_items(200);
        drain();

        write_reg(REG_MAX_ERROR, 24'd0);
        write_reg(REG_X_OFFSET, 24'h7FFFFF);
        write_reg(REG_Y_OFFSET, 24'h800000);
        write_reg(REG_RETRACT_HEIGHT, 24'h7FFFFF);
        random_items(100);
        hold_request = 1;
        random_items(100);
        drain();

        write_reg(REG_MAX_ERROR, 24'hFFFF);
        write_reg(REG_X_OFFSET, 24'h800000);
        write_reg(REG_Y_OFFSET, 24'h7FFFFF);
        write_reg(REG_RETRACT_HEIGHT, 24'h800000);
        random_items(200);
        drain();

        for (int p = 0; p < 2; p++)
        begin
            write_reg(REG_MAX_ERROR, $urandom_range(1, 40));
            write_reg(REG_X_OFFSET, $urandom);
            write_reg(REG_Y_OFFSET, $urandom);
            write_reg(REG_RETRACT_HEIGHT, $urandom);
            random_items(150);
            drain();
        end

        if (sb.errors == 0 && sb.expected_moves.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
